// ===== src/box_average_downsampler_assert.svh =====
// Assertion helpers used by the RTL file boxds_back.
`ifndef BOX_AVERAGE_DOWNSAMPLER_ASSERT_SVH
`define BOX_AVERAGE_DOWNSAMPLER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BOXDS_ASSERT_NOW(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("boxds assertion failed");

// Check cons in the cycle after ante.
`define BOXDS_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("boxds assertion failed");

`endif

// ===== src/boxds_pkg.sv =====
package boxds_pkg;

	localparam int DEF_MAX_OUT_WIDTH = 4096;
	localparam int DEF_MAX_FACTOR    = 16;
	localparam int DEF_CHANNELS      = 4;

	localparam int NUM_LANES  = 4;
	localparam int PIX_W      = 16;
	localparam int SUM_W      = 24;
	localparam int CNT_W      = 16;
	localparam int FACTOR_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_FACTOR  = 2'd0,
		CFG_SOURCE_WIDTH  = 2'd1,
		CFG_SOURCE_HEIGHT = 2'd2
	} cfg_index_t;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef pixel_t [NUM_LANES-1:0] pix_vec_t;

	typedef struct packed {
		logic first;
		logic last;
		logic row_end;
		logic frame_end;
	} blk_flags_t;

endpackage

// ===== src/boxds_ram.sv =====
module boxds_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/boxds_front.sv =====
module boxds_front import boxds_pkg::*; #(
	parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
	parameter int MAX_FACTOR    = DEF_MAX_FACTOR
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [CFG_IDX_W-1:0]                cfg_index,
	input  logic [CFG_DATA_W-1:0]               cfg_data,
	input  logic                                in_valid,
	input  logic                                frame_start,
	input  pix_vec_t                            pix,
	input  logic                                q_full,
	output logic                                push,
	output pix_vec_t                            push_pix,
	output logic [$clog2(MAX_OUT_WIDTH)-1:0]    push_addr,
	output logic [$clog2(MAX_FACTOR+1)-1:0]     push_f,
	output blk_flags_t                          push_flags
);

	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int CW = $clog2(MAX_FACTOR);
	localparam int IW = FW + 1;
	localparam int AW = $clog2(MAX_OUT_WIDTH);
	localparam int BW = $clog2(MAX_OUT_WIDTH + 1);
	localparam int PW = CNT_W + 2;

	logic [FACTOR_W-1:0] factor_q;
	logic [CNT_W-1:0]    width_q;
	logic [CNT_W-1:0]    height_q;

	logic [CNT_W-1:0] col_q, row_q;
	logic [CW-1:0]    cib_q, rib_q;
	logic [BW-1:0]    bc_q;

	logic [FW-1:0]    f_eff;
	logic [CNT_W-1:0] w_eff, h_eff;
	logic [CNT_W-1:0] x, y;
	logic [CW-1:0]    cib, rib;
	logic [BW-1:0]    bc;
	logic [PW-1:0]    x_end, y_end;
	logic             keep, accept, row_wrap;
	logic [IW-1:0]    cib_inc, rib_inc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_W'(1);
			width_q  <= CNT_W'(1);
			height_q <= CNT_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_BLOCK_FACTOR:  factor_q <= cfg_data[FACTOR_W-1:0];
				CFG_SOURCE_WIDTH:  width_q  <= cfg_data[CNT_W-1:0];
				CFG_SOURCE_HEIGHT: height_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the factor, treat zero sizes as one
	always_comb begin
		if (factor_q == '0) begin
			f_eff = FW'(1);
		end else if (32'(factor_q) > 32'(MAX_FACTOR)) begin
			f_eff = FW'(MAX_FACTOR);
		end else begin
			f_eff = FW'(factor_q);
		end
		w_eff = (width_q == '0) ? CNT_W'(1) : width_q;
		h_eff = (height_q == '0) ? CNT_W'(1) : height_q;
	end

	// frame start clears the position before the pixel is taken
	assign x   = frame_start ? '0 : col_q;
	assign y   = frame_start ? '0 : row_q;
	assign cib = frame_start ? '0 : cib_q;
	assign rib = frame_start ? '0 : rib_q;
	assign bc  = frame_start ? '0 : bc_q;

	// end of the current block, one past its last column or row
	assign x_end = PW'(x) + PW'(f_eff) - PW'(cib);
	assign y_end = PW'(y) + PW'(f_eff) - PW'(rib);

	assign keep = (x_end <= PW'(w_eff)) && (y_end <= PW'(h_eff))
		&& (bc < BW'(MAX_OUT_WIDTH));

	assign accept = in_valid && !q_full;
	assign push   = accept && keep;

	always_comb begin
		push_pix   = pix;
		push_addr  = bc[AW-1:0];
		push_f     = f_eff;
		push_flags.first     = (cib == '0) && (rib == '0);
		push_flags.last      = (FW'(cib) == f_eff - FW'(1)) && (FW'(rib) == f_eff - FW'(1));
		push_flags.row_end   = (bc == BW'(MAX_OUT_WIDTH - 1))
			|| (x_end + PW'(f_eff) > PW'(w_eff));
		push_flags.frame_end = push_flags.row_end
			&& (PW'(y) + PW'(1) + PW'(f_eff) > PW'(h_eff));
	end

	assign row_wrap = (PW'(x) + PW'(1)) >= PW'(w_eff);
	assign cib_inc  = IW'(cib) + IW'(1);
	assign rib_inc  = IW'(rib) + IW'(1);

	// advance the position on every transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
			bc_q  <= '0;
		end else if (accept) begin
			if (row_wrap) begin
				col_q <= '0;
				cib_q <= '0;
				bc_q  <= '0;
				row_q <= (y != '1) ? y + CNT_W'(1) : y;
				rib_q <= (rib_inc >= IW'(f_eff)) ? '0 : CW'(rib_inc);
			end else begin
				col_q <= x + CNT_W'(1);
				rib_q <= rib;
				row_q <= y;
				if (cib_inc >= IW'(f_eff)) begin
					cib_q <= '0;
					bc_q  <= (bc < BW'(MAX_OUT_WIDTH)) ? bc + BW'(1) : bc;
				end else begin
					cib_q <= CW'(cib_inc);
					bc_q  <= bc;
				end
			end
		end
	end

endmodule

// ===== src/boxds_queue.sv =====
module boxds_queue import boxds_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== src/boxds_back.sv =====
`include "box_average_downsampler_assert.svh"

module boxds_back import boxds_pkg::*; #(
	parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
	parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
	parameter int CHANNELS      = DEF_CHANNELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	output logic                             q_pop,
	input  pix_vec_t                         q_pix,
	input  logic [$clog2(MAX_OUT_WIDTH)-1:0] q_addr,
	input  logic [$clog2(MAX_FACTOR+1)-1:0]  q_f,
	input  blk_flags_t                       q_flags,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pix_vec_t                         avg,
	output logic                             row_end,
	output logic                             frame_end
);

	localparam int FW  = $clog2(MAX_FACTOR + 1);
	localparam int AW  = $clog2(MAX_OUT_WIDTH);
	localparam int RW  = SUM_W + 1;
	localparam int PRW = SUM_W + RW;
	localparam int SHW = $clog2(SUM_W + 2 * $clog2(MAX_FACTOR) + 1);
	localparam int TN  = 2 ** FW;

	typedef logic [RW-1:0]  recip_arr_t [TN];
	typedef logic [SHW-1:0] shift_arr_t [TN];
	typedef logic [CHANNELS-1:0][SUM_W-1:0] sum_vec_t;
	typedef logic [CHANNELS-1:0][PRW-1:0]   prod_vec_t;

	// ceil(2^(SUM_W+l) / f^2) with l = clog2(f^2): exact quotient for any 24-bit sum
	function automatic recip_arr_t build_recip();
		recip_arr_t       t;
		longint unsigned  d;
		longint unsigned  num;
		longint unsigned  rem;
		longint unsigned  quo;
		int               l;
		for (int i = 0; i < TN; i++) begin
			d   = (i >= 1 && i <= MAX_FACTOR) ? longint'(i * i) : 64'd1;
			l   = $clog2(d);
			num = (64'd1 << (SUM_W + l)) + d - 64'd1;
			// restoring long division, one quotient bit per step
			rem = 64'd0;
			quo = 64'd0;
			for (int b = 63; b >= 0; b--) begin
				rem = (rem << 1) | ((num >> b) & 64'd1);
				quo = quo << 1;
				if (rem >= d) begin
					rem = rem - d;
					quo = quo | 64'd1;
				end
			end
			t[i] = RW'(quo);
		end
		return t;
	endfunction

	function automatic shift_arr_t build_shift();
		shift_arr_t       t;
		longint unsigned  d;
		for (int i = 0; i < TN; i++) begin
			d    = (i >= 1 && i <= MAX_FACTOR) ? longint'(i * i) : 64'd1;
			t[i] = SHW'(SUM_W + $clog2(d));
		end
		return t;
	endfunction

	localparam recip_arr_t RECIP = build_recip();
	localparam shift_arr_t SHIFT = build_shift();

	// stage 1: read-modify-write of the column sum
	logic          s1_valid_q;
	pix_vec_t      s1_pix_q;
	logic [AW-1:0] s1_addr_q;
	logic [FW-1:0] s1_f_q;
	blk_flags_t    s1_flags_q;
	logic          s1_go, s1_to_s2;

	logic          last_wr_valid_q;
	logic [AW-1:0] last_addr_q;
	sum_vec_t      last_sum_q;

	sum_vec_t      rd_sum, s1_sum;
	logic          fwd;

	// stage 2: sum and reciprocal; stage 3: products
	logic           s2_valid_q, s2_re_q, s2_fe_q;
	sum_vec_t       s2_sum_q;
	logic [RW-1:0]  s2_recip_q;
	logic [SHW-1:0] s2_sh_q;
	logic           s2_ready, s2_adv;

	logic           s3_valid_q, s3_re_q, s3_fe_q;
	prod_vec_t      s3_prod_q;
	logic [SHW-1:0] s3_sh_q;
	logic           s3_ready, s3_adv;

	logic     out_valid_q, re_q, fe_q, out_free;
	pix_vec_t avg_q, avg_d;

	// handshake between stages, from the output backward
	assign out_free = !out_valid_q || !out_stall;
	assign s3_adv   = s3_valid_q && out_free;
	assign s3_ready = !s3_valid_q || out_free;
	assign s2_adv   = s2_valid_q && s3_ready;
	assign s2_ready = !s2_valid_q || s3_ready;
	assign s1_go    = s1_valid_q && (s2_ready || !s1_flags_q.last);
	assign s1_to_s2 = s1_go && s1_flags_q.last;
	assign q_pop    = !q_empty && (!s1_valid_q || s1_go);

	boxds_ram #(
		.WIDTH (CHANNELS * SUM_W),
		.DEPTH (MAX_OUT_WIDTH)
	) u_sums (
		.clk   (clk),
		.we    (s1_go),
		.waddr (s1_addr_q),
		.wdata (s1_sum),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (rd_sum)
	);

	// the write of the item just ahead lands on the same edge as this read: forward it
	assign fwd = last_wr_valid_q && (last_addr_q == s1_addr_q);

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (s1_flags_q.first) begin
				s1_sum[c] = SUM_W'(s1_pix_q[c]);
			end else begin
				s1_sum[c] = (fwd ? last_sum_q[c] : rd_sum[c]) + SUM_W'(s1_pix_q[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q      <= 1'b0;
			last_wr_valid_q <= 1'b0;
			s2_valid_q      <= 1'b0;
			s3_valid_q      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				last_wr_valid_q <= 1'b1;
			end
			if (s1_to_s2) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				s3_valid_q <= 1'b1;
			end else if (s3_adv) begin
				s3_valid_q <= 1'b0;
			end
			if (s3_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			s1_pix_q   <= q_pix;
			s1_addr_q  <= q_addr;
			s1_f_q     <= q_f;
			s1_flags_q <= q_flags;
		end
		if (s1_go) begin
			last_addr_q <= s1_addr_q;
			last_sum_q  <= s1_sum;
		end
		if (s1_to_s2) begin
			s2_sum_q   <= s1_sum;
			s2_recip_q <= RECIP[s1_f_q];
			s2_sh_q    <= SHIFT[s1_f_q];
			s2_re_q    <= s1_flags_q.row_end;
			s2_fe_q    <= s1_flags_q.frame_end;
		end
		if (s2_adv) begin
			for (int c = 0; c < CHANNELS; c++) begin
				s3_prod_q[c] <= PRW'(s2_sum_q[c]) * PRW'(s2_recip_q);
			end
			s3_sh_q <= s2_sh_q;
			s3_re_q <= s2_re_q;
			s3_fe_q <= s2_fe_q;
		end
		if (s3_adv) begin
			avg_q <= avg_d;
			re_q  <= s3_re_q;
			fe_q  <= s3_fe_q;
		end
	end

	// drop the fraction, saturate to the pixel range
	always_comb begin
		logic [PRW-1:0] quot;
		avg_d = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			quot = s3_prod_q[c] >> s3_sh_q;
			avg_d[c] = (|quot[PRW-1:PIX_W]) ? '1 : quot[PIX_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign avg       = avg_q;
	assign row_end   = re_q;
	assign frame_end = fe_q;

	`BOXDS_ASSERT_NOW(a_frame_end_has_row_end, clk, arst_n, out_valid_q && fe_q, re_q)
	`BOXDS_ASSERT_NEXT(a_s1_holds_when_blocked, clk, arst_n, s1_valid_q && !s1_go, s1_valid_q && $stable(s1_addr_q))
	`BOXDS_ASSERT_NEXT(a_forward_tracks_write, clk, arst_n, s1_go, last_wr_valid_q && (last_addr_q == $past(s1_addr_q)))

endmodule

// ===== src/box_average_downsampler.sv =====
// Path: a pixel that closes a block reaches out_valid through the stages of its
//   transaction (queue, sum read-modify-write, reciprocal lookup, multiply, shift).
// Throughput: one pixel per cycle unless out_stall backs up into a full queue; set by the
//   single read and write port of the column-sum memory, with same-column sums forwarded.
// Reset: position counters clear, registers return to factor 1, width 1, height 1. The
//   column-sum memory is not cleared; the first pixel of every block overwrites its entry.
module box_average_downsampler import boxds_pkg::*; #(
	parameter int MAX_OUT_WIDTH = DEF_MAX_OUT_WIDTH,
	parameter int MAX_FACTOR    = DEF_MAX_FACTOR,
	parameter int CHANNELS      = DEF_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      red_in,
	input  logic [PIX_W-1:0]      green_in,
	input  logic [PIX_W-1:0]      blue_in,
	input  logic [PIX_W-1:0]      infrared_in,
	input  logic                  frame_start,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      red_avg,
	output logic [PIX_W-1:0]      green_avg,
	output logic [PIX_W-1:0]      blue_avg,
	output logic [PIX_W-1:0]      infrared_avg,
	output logic                  row_end,
	output logic                  frame_end
);

	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int AW = $clog2(MAX_OUT_WIDTH);
	localparam int EW = $bits(pix_vec_t) + AW + FW + $bits(blk_flags_t);

	pix_vec_t      in_pix, avg;

	// front to queue
	logic          f_push;
	pix_vec_t      f_pix;
	logic [AW-1:0] f_addr;
	logic [FW-1:0] f_f;
	blk_flags_t    f_flags;

	// queue to back
	logic [EW-1:0] q_wdata, q_rdata;
	logic          q_full, q_empty, q_pop;
	pix_vec_t      b_pix;
	logic [AW-1:0] b_addr;
	logic [FW-1:0] b_f;
	blk_flags_t    b_flags;

	// registers are written at any time; the user keeps writes to idle periods
	assign cfg_ready = 1'b1;

	// hold the input only while the queue is full
	assign in_stall = q_full;
	assign in_pix   = {infrared_in, blue_in, green_in, red_in};

	// Front: track the raster position, drop pixels outside whole blocks or beyond the
	// widest output row, and tag each kept pixel with its block role and end marks.
	boxds_front #(
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH),
		.MAX_FACTOR    (MAX_FACTOR)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.frame_start (frame_start),
		.pix         (in_pix),
		.q_full      (q_full),
		.push        (f_push),
		.push_pix    (f_pix),
		.push_addr   (f_addr),
		.push_f      (f_f),
		.push_flags  (f_flags)
	);

	// Short queue: lets the front keep taking pixels while the back waits on out_stall.
	assign q_wdata = {f_pix, f_addr, f_f, f_flags};
	assign {b_pix, b_addr, b_f, b_flags} = q_rdata;

	boxds_queue #(
		.WIDTH (EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: accumulate into the column sums, then divide the closing sum by f*f with a
	// reciprocal multiply and deliver through the output register.
	boxds_back #(
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH),
		.MAX_FACTOR    (MAX_FACTOR),
		.CHANNELS      (CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_pix     (b_pix),
		.q_addr    (b_addr),
		.q_f       (b_f),
		.q_flags   (b_flags),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.avg       (avg),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	assign red_avg      = avg[0];
	assign green_avg    = avg[1];
	assign blue_avg     = avg[2];
	assign infrared_avg = avg[3];

endmodule

// ===== test/box_average_downsampler_test.sv =====
module box_average_downsampler_test;
	import boxds_pkg::*;

	// Clock, reset and run length
	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 1000000;
	// Wait after the last predicted mean before touching the registers
	localparam int DRAIN_CYCLES = 16;
	// Length of the long output hold that backs up the pipeline
	localparam int HOLD_CYCLES  = 150;
	localparam int RANDOM_ITEMS = 100;
	localparam int PRINT_CAP    = 40;

	// Block geometry as instantiated (package defaults)
	localparam int OUT_COLS   = DEF_MAX_OUT_WIDTH;
	localparam int FACTOR_CAP = DEF_MAX_FACTOR;
	localparam int CHANS      = DEF_CHANNELS;
	localparam int ROW_LIMIT  = (1 << CNT_W) - 1;

	// Index with no register behind it; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] infrared;
		logic             frame_start;
	} source_pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] infrared;
		logic             row_end;
		logic             frame_end;
	} mean_pixel_t;

	// Tracks the block's registers and position, predicts every block mean and
	// compares the means that come out against the predictions in order.
	class block_mean_tracker;
		logic [FACTOR_W-1:0] factor_reg;
		logic [CNT_W-1:0]    width_reg;
		logic [CNT_W-1:0]    height_reg;
		bit [SUM_W-1:0]      col_sum [OUT_COLS][CHANS];
		int unsigned         col_pos, row_pos, col_in_blk, row_in_blk, blk_col;
		mean_pixel_t         expected_means[$];
		int unsigned         error_count, pixel_count, mean_count;

		function new();
			factor_reg  = FACTOR_W'(1);
			width_reg   = CNT_W'(1);
			height_reg  = CNT_W'(1);
			col_pos     = 0;
			row_pos     = 0;
			col_in_blk  = 0;
			row_in_blk  = 0;
			blk_col     = 0;
			error_count = 0;
			pixel_count = 0;
			mean_count  = 0;
		endfunction

		function int unsigned pending();
			return expected_means.size();
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BLOCK_FACTOR:  factor_reg = data[FACTOR_W-1:0];
				CFG_SOURCE_WIDTH:  width_reg  = data;
				CFG_SOURCE_HEIGHT: height_reg = data;
				default: ;
			endcase
		endfunction

		function void take_pixel(source_pixel_t p);
			int unsigned      f, w, h, lw, lh, kept, x, y, q;
			logic [PIX_W-1:0] val [CHANS];
			logic [PIX_W-1:0] avg [CHANS];
			bit               first, last;
			mean_pixel_t      m;
			pixel_count++;
			f = factor_reg;
			if (f < 1) f = 1;
			if (f > FACTOR_CAP) f = FACTOR_CAP;
			w = (width_reg == 0) ? 1 : width_reg;
			h = (height_reg == 0) ? 1 : height_reg;
			lw = w / f;
			lh = h / f;
			kept = (lw < OUT_COLS) ? lw : OUT_COLS;
			val[0] = p.red;
			val[1] = p.green;
			val[2] = p.blue;
			val[3] = p.infrared;
			if (p.frame_start) begin
				col_pos    = 0;
				row_pos    = 0;
				col_in_blk = 0;
				row_in_blk = 0;
				blk_col    = 0;
			end
			x = col_pos;
			y = row_pos;
			if (x < lw * f && y < lh * f && blk_col < kept) begin
				first = (col_in_blk == 0) && (row_in_blk == 0);
				last  = (col_in_blk == f - 1) && (row_in_blk == f - 1);
				for (int c = 0; c < CHANS; c++)
					col_sum[blk_col][c] = first ? SUM_W'(val[c]) : col_sum[blk_col][c] + SUM_W'(val[c]);
				if (last) begin
					for (int c = 0; c < CHANS; c++) begin
						q = col_sum[blk_col][c] / (f * f);
						avg[c] = (q > ROW_LIMIT) ? '1 : PIX_W'(q);
					end
					m.red       = avg[0];
					m.green     = avg[1];
					m.blue      = avg[2];
					m.infrared  = avg[3];
					m.row_end   = (blk_col == kept - 1);
					m.frame_end = m.row_end && (y == lh * f - 1);
					expected_means.push_back(m);
				end
			end
			if (x >= w - 1) begin
				col_pos    = 0;
				col_in_blk = 0;
				blk_col    = 0;
				if (row_pos < ROW_LIMIT) row_pos++;
				row_in_blk++;
				if (row_in_blk >= f) row_in_blk = 0;
			end else begin
				col_pos = x + 1;
				col_in_blk++;
				if (col_in_blk >= f) begin
					col_in_blk = 0;
					if (blk_col < OUT_COLS) blk_col++;
				end
			end
		endfunction

		task report(string msg);
			if (error_count < PRINT_CAP) $display("[%0t] ERROR: %s", $time, msg);
			error_count++;
		endtask

		task compare_field(string name, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
			if (got !== want)
				report($sformatf("mean %0d: %s is %h, predicted %h", mean_count, name, got, want));
		endtask

		task check_mean(mean_pixel_t got);
			mean_pixel_t want;
			mean_count++;
			if (expected_means.size() == 0) begin
				report($sformatf("mean %0d arrived with none predicted: %h", mean_count, got));
				return;
			end
			want = expected_means.pop_front();
			compare_field("red_avg", got.red, want.red);
			compare_field("green_avg", got.green, want.green);
			compare_field("blue_avg", got.blue, want.blue);
			compare_field("infrared_avg", got.infrared, want.infrared);
			compare_field("row_end", got.row_end, want.row_end);
			compare_field("frame_end", got.frame_end, want.frame_end);
		endtask

		task check_drained();
			if (expected_means.size() != 0)
				report($sformatf("%0d predicted means never arrived", expected_means.size()));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      red_in;
	logic [PIX_W-1:0]      green_in;
	logic [PIX_W-1:0]      blue_in;
	logic [PIX_W-1:0]      infrared_in;
	logic                  frame_start;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      red_avg;
	logic [PIX_W-1:0]      green_avg;
	logic [PIX_W-1:0]      blue_avg;
	logic [PIX_W-1:0]      infrared_avg;
	logic                  row_end;
	logic                  frame_end;

	block_mean_tracker tracker = new();

	// Control shared between the stimulus and the receiver
	bit          calm = 1'b0;          // no idling on either side
	bit          hold_request = 1'b0;  // ask the receiver for one long hold
	int unsigned cycle_count = 0;
	int unsigned settings_count = 0;

	box_average_downsampler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.infrared_in  (infrared_in),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red_avg      (red_avg),
		.green_avg    (green_avg),
		.blue_avg     (blue_avg),
		.infrared_avg (infrared_avg),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Watchdog: end the run as failed if the cycle budget runs out
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Monitors: sample at the rising edge, before this edge's updates land,
	// so every transaction is seen with the values that were actually taken.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			tracker.apply_register(cfg_index, cfg_data);
		if (arst_n && in_valid && !in_stall)
			tracker.take_pixel({red_in, green_in, blue_in, infrared_in, frame_start});
		if (arst_n && out_valid && !out_stall)
			tracker.check_mean({red_avg, green_avg, blue_avg, infrared_avg, row_end, frame_end});
	end

	// Receiver: stall in random bursts, or hold off for one long stretch on request
	initial begin : receiver
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Mostly random samples, with the extremes turning up often
	function automatic logic [PIX_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// Offer one pixel and return right after the edge that takes it.
	// Leave in_valid high so a following pixel goes out back to back.
	task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, ir, input logic fs);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		red_in      <= r;
		green_in    <= g;
		blue_in     <= b;
		infrared_in <= ir;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
	endtask

	// Send a frame of count pixels, marking the first one as the frame start
	task automatic send_frame(input int unsigned count, input bit all_max);
		for (int unsigned i = 0; i < count; i++) begin
			if (all_max)
				send_pixel('1, '1, '1, '1, i == 0);
			else
				send_pixel(pick_level(), pick_level(), pick_level(), pick_level(), i == 0);
		end
	endtask

	// Drop in_valid, wait for every predicted mean, then let the pipe drain
	// past pixels that close no block.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Reprogram all three registers once the block is idle; hold cfg_valid
	// across the writes and drop it after the last one.
	task automatic program_geometry(input logic [CFG_DATA_W-1:0] factor_word, width_word,
			height_word, input bit poke_spare);
		settle();
		if (poke_spare) write_register(CFG_SPARE, CFG_DATA_W'($urandom));
		write_register(CFG_BLOCK_FACTOR, factor_word);
		write_register(CFG_SOURCE_WIDTH, width_word);
		write_register(CFG_SOURCE_HEIGHT, height_word);
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	// One random setting with small blocks, then one or two frames; some frames
	// are cut short by the next frame start, some run on into ignored rows.
	task automatic random_phase(output int unsigned sent);
		int unsigned           f_eff, cols, rows, count;
		logic [CFG_DATA_W-1:0] fword, wword, hword;
		fword = CFG_DATA_W'(($urandom & 32'hFFE0) | $urandom_range(0, 4));
		f_eff = (fword[FACTOR_W-1:0] == 0) ? 1 : fword[FACTOR_W-1:0];
		if ($urandom_range(0, 7) == 0)
			cols = $urandom_range(1, f_eff);
		else
			cols = f_eff * $urandom_range(1, 3) + $urandom_range(0, f_eff - 1);
		rows = f_eff * $urandom_range(1, 2) + $urandom_range(0, f_eff - 1);
		wword = CFG_DATA_W'(cols);
		hword = CFG_DATA_W'(rows);
		// Zero sizes read as one
		if (cols == 1 && $urandom_range(0, 1) == 0) wword = '0;
		if (rows == 1 && $urandom_range(0, 1) == 0) hword = '0;
		program_geometry(fword, wword, hword, $urandom_range(0, 7) == 0);
		sent = 0;
		repeat ($urandom_range(1, 2)) begin
			count = cols * rows;
			case ($urandom_range(0, 6))
				0: count += $urandom_range(1, cols);
				1: if (count > 1) count = $urandom_range(1, count - 1);
				default: ;
			endcase
			send_frame(count, 1'b0);
			sent += count;
		end
	endtask

	initial begin : stimulus
		int unsigned      random_items, sent;
		logic [PIX_W-1:0] v;

		// Drive every input to a known value and hold reset
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_BLOCK_FACTOR;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		red_in      <= '0;
		green_in    <= '0;
		blue_in     <= '0;
		infrared_in <= '0;
		frame_start <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is a single pixel with factor 1: the first pixel is a
		// whole frame even without a frame start, the next is an ignored row,
		// and a frame start brings the position back to the corner.
		send_pixel('1, '1, '1, '1, 1'b0);
		send_pixel(pick_level(), pick_level(), pick_level(), pick_level(), 1'b0);
		send_pixel('0, '0, '0, '0, 1'b1);

		// Factor 2 over 5 by 3: crop the last column and the last row. The two
		// kept blocks hold the extremes with the channels in opposite corners.
		program_geometry(CFG_DATA_W'(2), CFG_DATA_W'(5), CFG_DATA_W'(3), 1'b1);
		for (int i = 0; i < 11; i++) begin
			v = (i % 5 < 2) ? '1 : (i % 5 < 4) ? '0 : pick_level();
			if (i == 10) v = pick_level();
			send_pixel(v, ~v, v, ~v, i == 0);
		end

		// Factor 0 acts as 1, zero width and height act as 1
		program_geometry('0, '0, '0, 1'b0);
		send_frame(2, 1'b0);

		// Largest width and height with factor 16: no block closes this early
		program_geometry(CFG_DATA_W'(FACTOR_CAP), '1, '1, 1'b0);
		send_frame(8, 1'b0);

		// Hold off the receiver while pixels keep coming, so the block backs up
		program_geometry(CFG_DATA_W'(1), CFG_DATA_W'(8), CFG_DATA_W'(4), 1'b0);
		hold_request = 1'b1;
		send_frame(32, 1'b0);

		// Factor at or above the cap acts as 16; all-max pixels give the largest sum
		program_geometry(CFG_DATA_W'(($urandom & 32'hFFE0) | $urandom_range(FACTOR_CAP, 31)),
				CFG_DATA_W'(FACTOR_CAP), CFG_DATA_W'(FACTOR_CAP), 1'b0);
		send_frame(FACTOR_CAP * FACTOR_CAP, 1'b1);

		// Random settings and frames
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			random_phase(sent);
			random_items += sent;
		end

		// Last part without idling: one more random phase
		settle();
		calm = 1'b1;
		random_phase(sent);

		settle();
		tracker.check_drained();
		$display("Sent %0d pixel transactions and checked %0d mean transactions in %0d cycles",
				tracker.pixel_count, tracker.mean_count, cycle_count);
		$display("over %0d register settings: clamped factors, cropping, cut frames, long hold",
				settings_count);
		if (tracker.error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
